// File: rtl/lattice_coeff_compress_pack_defines.svh
// Assertion helpers for the coefficient packer.
`ifndef LATTICE_COEFF_COMPRESS_PACK_DEFINES_SVH
`define LATTICE_COEFF_COMPRESS_PACK_DEFINES_SVH

`ifndef ASSERT_OFF
`define LCCP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LCCP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define LCCP_ASSERT(lbl, clk, rst_n, prop, msg)
`define LCCP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// File: rtl/lccp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lccp_pkg;

    localparam int COEF_W   = 13;
    localparam int NUM_W    = 23;   // (lifted << 10) + half modulus
    localparam int Q_W      = 12;
    localparam int CODE_W   = 10;
    localparam int ACC_W    = 17;   // 7 pending bits + 10-bit code

    localparam logic [12:0] MODULUS      = 13'd3329;
    localparam logic [12:0] TWO_MODULUS  = 13'd6658;
    localparam logic [10:0] HALF_MODULUS = 11'd1664;

    // floor(2^23 / 3329); quotient estimate is low by at most one
    localparam logic [11:0] RECIP       = 12'd2519;
    localparam int          RECIP_SHIFT = 23;

    localparam logic [4:0] BITS_D9  = 5'd9;
    localparam logic [4:0] BITS_D10 = 5'd10;

    typedef enum logic {
        MODE_D9  = 1'b0,
        MODE_D10 = 1'b1
    } t_width_mode;

    typedef logic [NUM_W-1:0]  t_num;
    typedef logic [Q_W-1:0]    t_quot;
    typedef logic [CODE_W-1:0] t_code;

endpackage
`default_nettype wire

// File: rtl/lattice_coeff_compress_pack.sv
// Coefficient compressor and byte packer.
//
// Slave stream: one signed 13-bit coefficient per transfer (i_s_tdata[12:0]).
// Each coefficient is lifted into [0, 3329), compressed to a 9- or 10-bit code
// round(x * 2^d / 3329) mod 2^d and appended LSB first to a byte stream.
// Master stream: one byte per transfer; o_m_tlast marks the last byte that a
// coefficient produced. A coefficient yields one or two bytes.
// Config channel: i_cfg_data[0] selects the code width (0: 9 bits, 1: 10 bits).
// Write it only while the block is idle; it applies from the next coefficient.
//
// The first byte of a coefficient passes the input register, the quotient
// register (reciprocal multiply) and the output register (correction, packing).
// Throughput: one coefficient per cycle while bytes are taken, bounded by the byte
// port: a two-byte item holds the output register until its first byte is sent.
// Reset clears the pipeline, the pending bits and selects 9-bit codes.
// When the receiver stalls, the bytes wait in the output register and the
// pipeline fills up behind them before o_s_tready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "lattice_coeff_compress_pack_defines.svh"
module lattice_coeff_compress_pack (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_data,     // [0] width_mode
    // coefficient stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,      // [12:0] coefficient, [15:13] zero
    // byte stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,      // [7:0] packed_byte
    output logic             o_m_tlast       // last_of_item
);
    import lccp_pkg::*;

    t_width_mode       r_mode;

    // stage A: input register
    logic              r_a_v;
    logic [COEF_W-1:0] r_a_coef;
    t_width_mode       r_a_mode;

    // stage B: quotient estimate
    logic              r_b_v;
    t_quot             r_b_q0;
    t_num              r_b_num;
    t_width_mode       r_b_mode;

    // output buffer and packer state
    logic [1:0]        r_ocnt;
    logic [7:0]        r_byte0;
    logic [7:0]        r_byte1;
    logic [7:0]        r_pend;
    logic [2:0]        r_pcnt;

    logic              take_out;
    logic              b_load_ok;
    logic              a_adv;
    logic              in_xfer;
    logic              out_xfer;

    logic [COEF_W-1:0] a_lift;
    t_num              a_num;
    logic [34:0]       a_prod;

    t_num              b_qm;
    t_num              b_diff;
    logic [12:0]       b_rem;
    logic              b_fix;
    t_quot             b_q;
    t_code             b_code;

    logic [ACC_W-1:0]  p_acc;
    logic [4:0]        p_total;
    logic              p_two;
    logic [7:0]        n_pend;
    logic [2:0]        n_pcnt;

    assign o_cfg_ready = 1'b1;

    // backward ready chain
    assign take_out   = (r_ocnt == 2'd0) || ((r_ocnt == 2'd1) && i_m_tready);
    assign b_load_ok  = !r_b_v || take_out;
    assign a_adv      = r_a_v && b_load_ok;
    assign o_s_tready = !r_a_v || b_load_ok;
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign out_xfer   = o_m_tvalid && i_m_tready;

    // stage A: lift into [3329, 2*3329) so the quotient is never negative;
    // the extra modulus adds exactly 2^d, which the mask removes.
    always_comb begin
        if (r_a_coef[COEF_W-1]) begin
            a_lift = r_a_coef + TWO_MODULUS;
        end else begin
            a_lift = r_a_coef + MODULUS;
        end
        if (r_a_mode == MODE_D10) begin
            a_num = {a_lift, 10'b0} + {12'b0, HALF_MODULUS};
        end else begin
            a_num = {1'b0, a_lift, 9'b0} + {12'b0, HALF_MODULUS};
        end
        a_prod = {12'b0, a_num} * {23'b0, RECIP};
    end

    // stage B: one correction step on the quotient
    always_comb begin
        b_qm   = {11'b0, r_b_q0} * {10'b0, MODULUS};
        b_diff = r_b_num - b_qm;
        b_rem  = b_diff[12:0];
        b_fix  = (b_rem >= MODULUS);
        b_q    = r_b_q0 + {{(Q_W-1){1'b0}}, b_fix};
        if (r_b_mode == MODE_D10) begin
            b_code = b_q[CODE_W-1:0];
        end else begin
            b_code = {1'b0, b_q[8:0]};
        end
    end

    // packer: code goes above the pending bits
    always_comb begin
        p_acc   = {9'b0, r_pend} | ({7'b0, b_code} << r_pcnt);
        p_total = {2'b0, r_pcnt} + ((r_b_mode == MODE_D10) ? BITS_D10 : BITS_D9);
        p_two   = (p_total >= 5'd16);
        n_pcnt  = p_total[2:0];
        if (p_two) begin
            n_pend = {7'b0, p_acc[16]};
        end else begin
            n_pend = p_acc[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_D9;
            r_a_v  <= 1'b0;
            r_b_v  <= 1'b0;
            r_ocnt <= 2'd0;
            r_pend <= 8'd0;
            r_pcnt <= 3'd0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= t_width_mode'(i_cfg_data[0]);
            end

            if (o_s_tready) begin
                r_a_v <= i_s_tvalid;
            end
            if (b_load_ok) begin
                r_b_v <= r_a_v;
            end

            if (r_b_v && take_out) begin
                r_ocnt <= p_two ? 2'd2 : 2'd1;
                r_pend <= n_pend;
                r_pcnt <= n_pcnt;
            end else if (out_xfer) begin
                r_ocnt <= r_ocnt - 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_coef <= i_s_tdata[COEF_W-1:0];
            r_a_mode <= r_mode;
        end
        if (a_adv) begin
            r_b_q0   <= a_prod[RECIP_SHIFT +: Q_W];
            r_b_num  <= a_num;
            r_b_mode <= r_a_mode;
        end
        if (r_b_v && take_out) begin
            r_byte0 <= p_acc[7:0];
            r_byte1 <= p_acc[15:8];
        end else if (out_xfer && (r_ocnt == 2'd2)) begin
            r_byte0 <= r_byte1;
        end
    end

    assign o_m_tvalid = (r_ocnt != 2'd0);
    assign o_m_tdata  = r_byte0;
    assign o_m_tlast  = (r_ocnt == 2'd1);

    `LCCP_ASSERT(a_pend_clean, i_clk, i_rst_n, ((r_pend >> r_pcnt) == 8'd0), "pending bits above count not zero")
    `LCCP_ASSERT(a_ocnt_max, i_clk, i_rst_n, (r_ocnt != 2'd3), "output buffer over two bytes")
    `LCCP_ASSERT(a_rem_fixed, i_clk, i_rst_n, (r_b_v |-> (b_diff < {10'b0, TWO_MODULUS})), "quotient estimate off by more than one")
    `LCCP_ASSERT_NEXT(a_pack_shows, i_clk, i_rst_n, (r_b_v && take_out), o_m_tvalid, "packed item gave no byte")
    `LCCP_ASSERT_NEXT(a_pair_second, i_clk, i_rst_n, (out_xfer && (r_ocnt == 2'd2)), o_m_tvalid, "second byte of pair lost")

endmodule
`default_nettype wire
